// ----- sv/tmlp_pkg.sv -----
// ----------------------------------------------------------------------------
// tmlp_pkg: shared types and codes for the tiny MLP evaluator
// Item structs, command codes, activation codes, the sequencer state set and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tmlp_pkg;

    localparam int OUTPUT_NODES = 3;

    typedef struct packed {
        logic [2:0]         command;
        logic [5:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] sample;
    } tmlp_in_t;

    typedef struct packed {
        logic signed [31:0] out_first;
        logic signed [31:0] out_second;
        logic signed [31:0] out_third;
        logic               saturated;
    } tmlp_out_t;

    // item commands
    localparam logic [2:0] CMD_NODE_WEIGHT = 3'd0;
    localparam logic [2:0] CMD_NODE_BIAS   = 3'd1;
    localparam logic [2:0] CMD_NODE_ACT    = 3'd2;
    localparam logic [2:0] CMD_OUT_WEIGHT  = 3'd3;
    localparam logic [2:0] CMD_EVALUATE    = 3'd4;

    // activation codes
    localparam logic [1:0] ACT_IDENT   = 2'd0;
    localparam logic [1:0] ACT_SIGMOID = 2'd1;
    localparam logic [1:0] ACT_RELU    = 2'd2;
    localparam logic [1:0] ACT_COSH    = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_HIDDEN_COUNT = 2'd0;
    localparam logic [1:0] CFG_NORM_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_NORM_CEILING = 2'd2;

    // divider runs 17 restoring steps (quotient never exceeds 1.0 in Q16.16)
    localparam logic [4:0] DIV_LAST = 5'd16;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM,
        ST_NDIV,
        ST_NTAKE,
        ST_NRD,
        ST_NMUL,
        ST_NSUM,
        ST_ORD,
        ST_OMUL,
        ST_OACC,
        ST_OSUM,
        ST_ACT,
        ST_EXP1,
        ST_EXP2,
        ST_EXP3,
        ST_SIGSET,
        ST_SDIV,
        ST_FIN,
        ST_DONE
    } tmlp_state_t;

    typedef enum logic [1:0] {
        KIND_IN,
        KIND_HID,
        KIND_OUT
    } tmlp_kind_t;

    typedef struct packed {
        logic store_wr;
        logic eval_start;
        logic norm_setup;
        logic norm_take;
        logic div_step;
        logic mul_in;
        logic mul_out;
        logic sum_in;
        logic sum_out;
        logic acc_clear;
        logic acc_add;
        logic exp1;
        logic exp_neg;
        logic exp2;
        logic exp3;
        logic sig_setup;
        logic fin_in;
        logic fin_hid;
        logic fin_out;
    } tmlp_cmd_t;

    typedef struct packed {
        logic       norm_direct;
        logic [1:0] act_code;
    } tmlp_stat_t;

endpackage

// ----- sv/tmlp_dp.sv -----
// ----------------------------------------------------------------------------
// tmlp_dp: datapath of the tiny MLP evaluator
// Parameter stores, hidden scratch, shared MAC, exp unit and restoring divider.
// ----------------------------------------------------------------------------
module tmlp_dp import tmlp_pkg::*; #(
    parameter int MAX_HIDDEN = 20,
    localparam int NODE_COUNT = MAX_HIDDEN + 1 + OUTPUT_NODES,
    localparam int OW_COUNT = OUTPUT_NODES * MAX_HIDDEN,
    localparam int NODE_AW = $clog2(NODE_COUNT),
    localparam int OW_AW = $clog2(OW_COUNT),
    localparam int SAW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1
) (
    input  logic               clk,
    input  tmlp_cmd_t          cmd,
    input  tmlp_in_t           item,
    input  logic [30:0]        ceiling,
    input  logic [NODE_AW-1:0] node_addr,
    input  logic [OW_AW-1:0]   ow_addr,
    input  logic [SAW-1:0]     scr_addr,
    input  logic [1:0]         out_sel,
    output tmlp_stat_t         stat,
    output tmlp_out_t          result
);

    localparam logic [17:0] POW2_FRAC [0:16] = '{
        18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
        18'd84990, 18'd88753, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
    };

    typedef struct packed {
        logic signed [31:0] value;
        logic               ovf;
    } sat_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sh7FFF_FFFF)
        begin
            r.value = 32'sh7FFF_FFFF;
            r.ovf   = 1'b1;
        end
        else if (v < -64'sh8000_0000)
        begin
            r.value = 32'sh8000_0000;
            r.ovf   = 1'b1;
        end
        else
        begin
            r.value = v[31:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

    // stores
    logic signed [31:0] node_w_mem [NODE_COUNT];
    logic signed [31:0] node_b_mem [NODE_COUNT];
    logic [1:0]         node_a_mem [NODE_COUNT];
    logic signed [31:0] ow_mem [OW_COUNT];
    logic signed [31:0] scr_mem [MAX_HIDDEN];

    logic signed [31:0] w_rd_reg, b_rd_reg, ow_rd_reg, scr_rd_reg;
    logic [1:0]         a_rd_reg;

    // working registers
    logic signed [31:0] x_reg, val_reg;
    logic signed [47:0] prod_reg;
    logic signed [55:0] acc_reg;
    logic signed [35:0] t_reg;
    logic signed [19:0] ip_reg;
    logic [17:0]        m_reg;
    logic [48:0]        e1_reg, e2_reg;
    logic [47:0]        rem_reg;
    logic [65:0]        dsh_reg;
    logic [16:0]        q_reg;
    logic               sat_reg;
    logic signed [31:0] res0_reg, res1_reg, res2_reg;

    // write decode
    logic               wr_node_ok, wr_ow_ok;
    logic [NODE_AW-1:0] wr_node_addr;
    logic [OW_AW-1:0]   wr_ow_addr;

    assign wr_node_ok   = cmd.store_wr && (int'(item.entry_index) < NODE_COUNT);
    assign wr_ow_ok     = cmd.store_wr && (int'(item.entry_index) < OW_COUNT);
    assign wr_node_addr = NODE_AW'(item.entry_index);
    assign wr_ow_addr   = OW_AW'(item.entry_index);

    always_ff @(posedge clk)
    begin
        if (wr_node_ok && item.command == CMD_NODE_WEIGHT)
        begin
            node_w_mem[wr_node_addr] <= item.entry_value;
        end
        w_rd_reg <= node_w_mem[node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_node_ok && item.command == CMD_NODE_BIAS)
        begin
            node_b_mem[wr_node_addr] <= item.entry_value;
        end
        b_rd_reg <= node_b_mem[node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_node_ok && item.command == CMD_NODE_ACT)
        begin
            node_a_mem[wr_node_addr] <= item.entry_value[1:0];
        end
        a_rd_reg <= node_a_mem[node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_ow_ok && item.command == CMD_OUT_WEIGHT)
        begin
            ow_mem[wr_ow_addr] <= item.entry_value;
        end
        ow_rd_reg <= ow_mem[ow_addr];
    end

    // MAC: Q16.16 product rounded half up
    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] mul_full, mul_rnd;

    assign mul_x    = cmd.mul_out ? scr_rd_reg : x_reg;
    assign mul_y    = cmd.mul_out ? ow_rd_reg : w_rd_reg;
    assign mul_full = mul_x * mul_y;
    assign mul_rnd  = mul_full + 64'sd32768;

    logic signed [63:0] sum_wide;
    sat_t               sum_sat;

    assign sum_wide = cmd.sum_out ? (64'(acc_reg) + 64'(b_rd_reg))
                                  : (64'(prod_reg) + 64'(b_rd_reg));
    assign sum_sat  = sat32(sum_wide);

    // exp: 2^(x*log2e), table + linear interpolation, then shift
    logic signed [32:0] exp_x;
    logic signed [51:0] exp_prod;
    logic [3:0]         fr_j;
    logic [11:0]        fr_r;
    logic [17:0]        p_lo, p_hi, p_d;
    logic [29:0]        interp;
    logic [19:0]        ip_neg;
    logic [48:0]        exp_res;

    assign exp_x    = cmd.exp_neg ? -33'(val_reg) : 33'(val_reg);
    assign exp_prod = 52'(exp_x) * 52'sd94548 + 52'sd32768;
    assign fr_j     = t_reg[15:12];
    assign fr_r     = t_reg[11:0];
    assign p_lo     = POW2_FRAC[fr_j];
    assign p_hi     = POW2_FRAC[5'(fr_j) + 5'd1];
    assign p_d      = p_hi - p_lo;
    assign interp   = (30'(p_d) * 30'(fr_r)) >> 12;
    assign ip_neg   = -ip_reg;

    always_comb
    begin
        if (ip_reg >= 20'sd31)
        begin
            exp_res = 49'h1_0000_0000_0000;
        end
        else if (ip_reg >= 20'sd0)
        begin
            exp_res = 49'(m_reg) << ip_reg[4:0];
        end
        else if (ip_reg <= -20'sd18)
        begin
            exp_res = '0;
        end
        else
        begin
            exp_res = 49'(m_reg) >> ip_neg[4:0];
        end
    end

    // divider operands
    logic [49:0] sig_den;
    logic [47:0] sig_num;
    logic [31:0] norm_mag;
    logic        norm_big, norm_zero, div_ge;

    assign sig_den   = 50'(e1_reg) + 50'd65536;
    assign sig_num   = 48'(sig_den >> 1) + 48'h1_0000_0000;
    assign norm_mag  = x_reg[31] ? -x_reg : x_reg;
    assign norm_big  = norm_mag > {1'b0, ceiling};
    assign norm_zero = (ceiling == '0);
    assign div_ge    = 66'(rem_reg) >= dsh_reg;

    // activation result
    logic [49:0]        cosh_sum;
    logic               cosh_sat;
    logic signed [31:0] act_res;
    logic               fin_any;

    assign cosh_sum = (50'(e1_reg) + 50'(e2_reg)) >> 1;
    assign cosh_sat = cosh_sum > 50'h7FFF_FFFF;
    assign fin_any  = cmd.fin_in || cmd.fin_hid || cmd.fin_out;

    always_comb
    begin
        unique case (a_rd_reg)
            ACT_IDENT:   act_res = val_reg;
            ACT_SIGMOID: act_res = {15'b0, q_reg};
            ACT_RELU:    act_res = (val_reg <= 32'sd0) ? 32'sd0 : val_reg;
            ACT_COSH:    act_res = cosh_sat ? 32'sh7FFF_FFFF : cosh_sum[31:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_hid)
        begin
            scr_mem[scr_addr] <= act_res;
        end
        scr_rd_reg <= scr_mem[scr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            x_reg <= item.sample;
        end
        else if (cmd.norm_setup && norm_big)
        begin
            x_reg <= 32'sd65536;
        end
        else if (cmd.norm_setup && norm_zero)
        begin
            x_reg <= 32'sd0;
        end
        else if (cmd.norm_take)
        begin
            x_reg <= {15'b0, q_reg};
        end
        else if (cmd.fin_in)
        begin
            x_reg <= act_res;
        end

        if (cmd.mul_in || cmd.mul_out)
        begin
            prod_reg <= mul_rnd[63:16];
        end

        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + 56'(prod_reg);
        end

        if (cmd.sum_in || cmd.sum_out)
        begin
            val_reg <= sum_sat.value;
        end

        if (cmd.exp1)
        begin
            t_reg <= exp_prod[51:16];
        end
        if (cmd.exp2)
        begin
            ip_reg <= t_reg[35:16];
            m_reg  <= p_lo + interp[17:0];
        end
        if (cmd.exp3)
        begin
            e2_reg <= e1_reg;
            e1_reg <= exp_res;
        end

        // restoring divider, one quotient bit per step
        if (cmd.norm_setup)
        begin
            rem_reg <= 48'(norm_mag) << 16;
            dsh_reg <= 66'(ceiling) << 16;
            q_reg   <= '0;
        end
        else if (cmd.sig_setup)
        begin
            rem_reg <= sig_num;
            dsh_reg <= 66'(sig_den) << 16;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsh_reg[47:0];
            end
            q_reg   <= {q_reg[15:0], div_ge};
            dsh_reg <= dsh_reg >> 1;
        end

        if (cmd.eval_start)
        begin
            sat_reg <= 1'b0;
        end
        else if (((cmd.sum_in || cmd.sum_out) && sum_sat.ovf)
                 || (fin_any && a_rd_reg == ACT_COSH && cosh_sat))
        begin
            sat_reg <= 1'b1;
        end

        if (cmd.fin_out)
        begin
            if (out_sel == 2'd0)
            begin
                res0_reg <= act_res;
            end
            else if (out_sel == 2'd1)
            begin
                res1_reg <= act_res;
            end
            else
            begin
                res2_reg <= act_res;
            end
        end
    end

    assign stat.norm_direct = norm_big || norm_zero;
    assign stat.act_code    = a_rd_reg;

    assign result.out_first  = res0_reg;
    assign result.out_second = res1_reg;
    assign result.out_third  = res2_reg;
    assign result.saturated  = sat_reg;

endmodule

// ----- sv/tmlp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tmlp_ctrl: sequencer of the tiny MLP evaluator
// Walks normalise, input node, hidden nodes and output nodes; drives the
// datapath with one command bundle per cycle.
// ----------------------------------------------------------------------------
module tmlp_ctrl import tmlp_pkg::*; #(
    parameter int MAX_HIDDEN = 20,
    localparam int NODE_COUNT = MAX_HIDDEN + 1 + OUTPUT_NODES,
    localparam int OW_COUNT = OUTPUT_NODES * MAX_HIDDEN,
    localparam int NODE_AW = $clog2(NODE_COUNT),
    localparam int OW_AW = $clog2(OW_COUNT),
    localparam int HCW = $clog2(MAX_HIDDEN + 1),
    localparam int SAW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         command,
    input  logic [HCW-1:0]     n_hidden,
    input  logic               norm_enable,
    input  tmlp_stat_t         stat,
    output logic               busy,
    output logic               done,
    output tmlp_cmd_t          cmd,
    output logic [NODE_AW-1:0] node_addr,
    output logic [OW_AW-1:0]   ow_addr,
    output logic [SAW-1:0]     scr_addr,
    output logic [1:0]         out_sel
);

    tmlp_state_t    state_reg, state_next;
    tmlp_kind_t     kind_reg, kind_next;
    logic [HCW-1:0] h_reg, h_next;
    logic [1:0]     o_reg, o_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic           pass_reg, pass_next;
    logic [HCW-1:0] h_last;

    assign h_last = n_hidden - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_IN;
            h_reg     <= '0;
            o_reg     <= '0;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            h_reg     <= h_next;
            o_reg     <= o_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        h_next     = h_reg;
        o_next     = o_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.store_wr = 1'b1;
                    if (command == CMD_EVALUATE)
                    begin
                        cmd.eval_start = 1'b1;
                        state_next     = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                kind_next = KIND_IN;
                if (!norm_enable)
                begin
                    state_next = ST_NRD;
                end
                else
                begin
                    cmd.norm_setup = 1'b1;
                    cnt_next       = '0;
                    state_next     = stat.norm_direct ? ST_NRD : ST_NDIV;
                end
            end
            ST_NDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_NTAKE;
                end
            end
            ST_NTAKE:
            begin
                cmd.norm_take = 1'b1;
                state_next    = ST_NRD;
            end
            ST_NRD:
            begin
                if (kind_reg == KIND_OUT)
                begin
                    cmd.acc_clear = 1'b1;
                    h_next        = '0;
                    state_next    = (n_hidden == '0) ? ST_OSUM : ST_ORD;
                end
                else
                begin
                    state_next = ST_NMUL;
                end
            end
            ST_NMUL:
            begin
                cmd.mul_in = 1'b1;
                state_next = ST_NSUM;
            end
            ST_NSUM:
            begin
                cmd.sum_in = 1'b1;
                state_next = ST_ACT;
            end
            ST_ORD:
            begin
                state_next = ST_OMUL;
            end
            ST_OMUL:
            begin
                cmd.mul_out = 1'b1;
                state_next  = ST_OACC;
            end
            ST_OACC:
            begin
                cmd.acc_add = 1'b1;
                if (h_reg == h_last)
                begin
                    state_next = ST_OSUM;
                end
                else
                begin
                    h_next     = h_reg + 1'b1;
                    state_next = ST_ORD;
                end
            end
            ST_OSUM:
            begin
                cmd.sum_out = 1'b1;
                state_next  = ST_ACT;
            end
            ST_ACT:
            begin
                pass_next = 1'b0;
                if (stat.act_code == ACT_SIGMOID || stat.act_code == ACT_COSH)
                begin
                    state_next = ST_EXP1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_EXP1:
            begin
                cmd.exp1    = 1'b1;
                cmd.exp_neg = (stat.act_code == ACT_SIGMOID) || pass_reg;
                state_next  = ST_EXP2;
            end
            ST_EXP2:
            begin
                cmd.exp2   = 1'b1;
                state_next = ST_EXP3;
            end
            ST_EXP3:
            begin
                cmd.exp3 = 1'b1;
                if (stat.act_code == ACT_COSH && !pass_reg)
                begin
                    pass_next  = 1'b1;
                    state_next = ST_EXP1;
                end
                else if (stat.act_code == ACT_SIGMOID)
                begin
                    state_next = ST_SIGSET;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SIGSET:
            begin
                cmd.sig_setup = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SDIV;
            end
            ST_SDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_NRD;
                unique case (kind_reg)
                    KIND_IN:
                    begin
                        cmd.fin_in = 1'b1;
                        h_next     = '0;
                        o_next     = '0;
                        kind_next  = (n_hidden == '0) ? KIND_OUT : KIND_HID;
                    end
                    KIND_HID:
                    begin
                        cmd.fin_hid = 1'b1;
                        if (h_reg == h_last)
                        begin
                            kind_next = KIND_OUT;
                            o_next    = '0;
                            h_next    = '0;
                        end
                        else
                        begin
                            h_next = h_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.fin_out = 1'b1;
                        if (o_reg == 2'd2)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            o_next = o_reg + 2'd1;
                        end
                    end
                endcase
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (kind_reg)
            KIND_IN:  node_addr = '0;
            KIND_HID: node_addr = NODE_AW'(h_reg) + 1'b1;
            default:  node_addr = NODE_AW'(MAX_HIDDEN + 1) + NODE_AW'(o_reg);
        endcase
    end

    assign ow_addr  = OW_AW'(OW_AW'(o_reg) * OW_AW'(MAX_HIDDEN) + OW_AW'(h_reg));
    assign scr_addr = h_reg[SAW-1:0];
    assign out_sel  = o_reg;
    assign busy     = (state_reg != ST_IDLE);
    assign done     = (state_reg == ST_DONE);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result strobe");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && command == CMD_EVALUATE))
        else $error("went busy without evaluate");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NDIV || state_reg == ST_SDIV) |-> cnt_reg <= DIV_LAST)
        else $error("divider step count overrun");

    a_acc_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OACC) |-> (n_hidden != '0 && h_reg <= h_last))
        else $error("accumulate with no hidden node");

endmodule

// ----- sv/tiny_mlp_forward_pass.sv -----
// ----------------------------------------------------------------------------
// tiny_mlp_forward_pass: tiny feed-forward net evaluator, Q16.16
// One input node, up to MAX_HIDDEN hidden nodes, three output nodes. Write
// items load weights, biases, activations and output weights; an evaluate
// item produces the three outputs and a saturation flag.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  --------  -----------------------------  ---------------------------------
//  item in   item (tmlp_in_t)               taken when start && !busy
//  result    result (tmlp_out_t)            valid for the one cycle done is high
//  config    cfg_wr, cfg_addr, cfg_data     written when cfg_wr is high
//
// Write items never raise busy.
// An evaluate runs on one shared MAC, an exp unit (states EXP1 to EXP3) and a 17-step
// restoring divider: the normalise, then per input/hidden node a multiply and
// a sum plus the activation (identity/relu direct, an exp and a divide for
// sigmoid, two exp passes for cosh), per output node one multiply-accumulate
// per hidden node, then the sum and the activation.
// Reset (rst_n low, async) returns the sequencer to idle and restores the
// config registers; the stores are undefined until written.
// The receiver cannot stall: the result is shown for one cycle with done.
// ----------------------------------------------------------------------------
module tiny_mlp_forward_pass import tmlp_pkg::*; #(
    parameter int MAX_HIDDEN = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tmlp_in_t    item,
    output logic        done,
    output tmlp_out_t   result,
    input  logic        cfg_wr,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_data
);

    localparam int NODE_COUNT = MAX_HIDDEN + 1 + OUTPUT_NODES;
    localparam int OW_COUNT   = OUTPUT_NODES * MAX_HIDDEN;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int OW_AW      = $clog2(OW_COUNT);
    localparam int HCW        = $clog2(MAX_HIDDEN + 1);
    localparam int SAW        = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;

    // configuration registers
    logic [4:0]  hidden_count_reg;
    logic        norm_enable_reg;
    logic [30:0] norm_ceiling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidden_count_reg <= 5'd5;
            norm_enable_reg  <= 1'b1;
            norm_ceiling_reg <= 31'd65536;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_addr)
                CFG_HIDDEN_COUNT: hidden_count_reg <= cfg_data[4:0];
                CFG_NORM_ENABLE:  norm_enable_reg  <= cfg_data[0];
                CFG_NORM_CEILING: norm_ceiling_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // hidden count beyond the store depth is clamped
    logic [HCW-1:0] n_hidden;

    assign n_hidden = (int'(hidden_count_reg) > MAX_HIDDEN) ? HCW'(MAX_HIDDEN)
                                                            : HCW'(hidden_count_reg);

    tmlp_cmd_t          cmd;
    tmlp_stat_t         stat;
    logic [NODE_AW-1:0] node_addr;
    logic [OW_AW-1:0]   ow_addr;
    logic [SAW-1:0]     scr_addr;
    logic [1:0]         out_sel;

    tmlp_ctrl #(
        .MAX_HIDDEN (MAX_HIDDEN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (item.command),
        .n_hidden    (n_hidden),
        .norm_enable (norm_enable_reg),
        .stat        (stat),
        .busy        (busy),
        .done        (done),
        .cmd         (cmd),
        .node_addr   (node_addr),
        .ow_addr     (ow_addr),
        .scr_addr    (scr_addr),
        .out_sel     (out_sel)
    );

    tmlp_dp #(
        .MAX_HIDDEN (MAX_HIDDEN)
    ) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .item      (item),
        .ceiling   (norm_ceiling_reg),
        .node_addr (node_addr),
        .ow_addr   (ow_addr),
        .scr_addr  (scr_addr),
        .out_sel   (out_sel),
        .stat      (stat),
        .result    (result)
    );

endmodule
